// ===== rtl/kclc_pkg.sv =====
// Package for the keypad code lock controller.
// Holds phase and event codes, key characters, register indexes and the keypad table.
// No dependencies.
package kclc_pkg;

	localparam int CODE_LENGTH_DEF = 4;

	localparam int KEY_W   = 5;
	localparam int CHAR_W  = 8;
	localparam int FAIL_W  = 4;
	localparam int POS_W   = 3;
	localparam int MCODE_W = 40;
	localparam int APB_AW  = 5;
	localparam int APB_DW  = 64;

	localparam logic [CHAR_W-1:0] CHAR_STAR = 8'd42;
	localparam logic [CHAR_W-1:0] CHAR_HASH = 8'd35;
	localparam logic [CHAR_W-1:0] CHAR_NONE = 8'hFF;
	localparam logic [CHAR_W-1:0] CHAR_0 = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_2 = 8'h32;
	localparam logic [CHAR_W-1:0] CHAR_3 = 8'h33;
	localparam logic [CHAR_W-1:0] CHAR_4 = 8'h34;
	localparam logic [CHAR_W-1:0] CHAR_5 = 8'h35;
	localparam logic [CHAR_W-1:0] CHAR_8 = 8'h38;

	localparam logic [MCODE_W-1:0] MASTER_RST = {CHAR_2, CHAR_3, CHAR_4, CHAR_5, CHAR_5};
	localparam logic [FAIL_W-1:0]  MAX_FAIL_RST = 4'd3;
	localparam logic [FAIL_W-1:0]  RETAIN_RST   = 4'd2;
	localparam logic [FAIL_W-1:0]  FAIL_SAT     = 4'd15;

	localparam logic [1:0] REG_MASTER = 2'd0;
	localparam logic [1:0] REG_MAXFAIL = 2'd1;
	localparam logic [1:0] REG_RETAIN = 2'd2;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_ENTRY   = 2'd1,
		PH_MASTER  = 2'd2,
		PH_NEWCODE = 2'd3
	} phase_t;

	typedef enum logic [3:0] {
		EV_NONE     = 4'd0,
		EV_KEY      = 4'd1,
		EV_GRANTED  = 4'd2,
		EV_RELOCKED = 4'd3,
		EV_DENIED   = 4'd4,
		EV_LOCKOUT  = 4'd5,
		EV_CHANGED  = 4'd6,
		EV_CHG_ERR  = 4'd7,
		EV_RESTART  = 4'd8
	} event_t;

	typedef struct packed {
		logic [MCODE_W-1:0] master_code;
		logic [FAIL_W-1:0]  max_failures;
		logic [FAIL_W-1:0]  retained_failures;
	} cfg_t;

	typedef struct packed {
		phase_t             phase;
		logic [CHAR_W-1:0]  key_char;
		logic [POS_W-1:0]   position;
		event_t             event_res;
		logic               unlocked;
		logic               lock_released;
		logic               alarm;
		logic [FAIL_W-1:0]  failures;
	} res_t;

	function automatic logic [CHAR_W-1:0] key_to_ascii(input logic [KEY_W-1:0] code);
		logic [CHAR_W-1:0] c;
		unique case (code)
			5'd1:    c = 8'h31;
			5'd2:    c = 8'h32;
			5'd3:    c = 8'h33;
			5'd4:    c = 8'h41;
			5'd5:    c = 8'h34;
			5'd6:    c = 8'h35;
			5'd7:    c = 8'h36;
			5'd8:    c = 8'h42;
			5'd9:    c = 8'h37;
			5'd10:   c = 8'h38;
			5'd11:   c = 8'h39;
			5'd12:   c = 8'h43;
			5'd13:   c = CHAR_STAR;
			5'd14:   c = 8'h30;
			5'd15:   c = CHAR_HASH;
			5'd16:   c = 8'h44;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [CHAR_W-1:0] default_code_char(input int unsigned k);
		logic [CHAR_W-1:0] c;
		unique case (k)
			0:       c = CHAR_2;
			1:       c = CHAR_5;
			2:       c = CHAR_8;
			default: c = CHAR_0;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/kclc_if.sv =====
// Valid/ready channel interfaces for the keypad code lock controller.
// Depends on kclc_pkg.
interface kclc_key_if;
	logic                        valid;
	logic                        ready;
	logic [kclc_pkg::KEY_W-1:0]  key_code;
	logic                        door_sensor;

	modport source (output valid, key_code, door_sensor, input ready);
	modport sink (input valid, key_code, door_sensor, output ready);
endinterface

interface kclc_res_if;
	logic                         valid;
	logic                         ready;
	kclc_pkg::phase_t             phase;
	logic [kclc_pkg::CHAR_W-1:0]  key_char;
	logic [kclc_pkg::POS_W-1:0]   position;
	kclc_pkg::event_t             event_res;
	logic                         unlocked;
	logic                         lock_released;
	logic                         alarm;
	logic [kclc_pkg::FAIL_W-1:0]  failures;

	modport source (output valid, phase, key_char, position, event_res, unlocked,
		lock_released, alarm, failures, input ready);
	modport sink (input valid, phase, key_char, position, event_res, unlocked,
		lock_released, alarm, failures, output ready);
endinterface

// ===== rtl/kclc_step.sv =====
// Next-state and result logic for one keypad transaction.
// Depends on kclc_pkg.
module kclc_step #(
	parameter int CODE_LENGTH = kclc_pkg::CODE_LENGTH_DEF,
	localparam int ENTRY_LEN = CODE_LENGTH + 1,
	localparam int CNT_W = $clog2(ENTRY_LEN + 1)
) (
	input  logic [kclc_pkg::KEY_W-1:0]   key_code,
	input  logic                         door_sensor,
	input  kclc_pkg::cfg_t               cfg,
	input  kclc_pkg::phase_t             phase,
	input  logic [CNT_W-1:0]             count,
	input  logic [kclc_pkg::CHAR_W-1:0]  entry_buf [ENTRY_LEN],
	input  logic [kclc_pkg::CHAR_W-1:0]  stored [CODE_LENGTH],
	input  logic [kclc_pkg::FAIL_W-1:0]  fail,
	input  logic                         granted,
	output kclc_pkg::phase_t             phase_n,
	output logic [CNT_W-1:0]             count_n,
	output logic                         buf_we,
	output logic [kclc_pkg::CHAR_W-1:0]  entry_buf_n [ENTRY_LEN],
	output logic                         stored_we,
	output logic [kclc_pkg::FAIL_W-1:0]  fail_n,
	output logic                         granted_n,
	output kclc_pkg::res_t               res
);

	logic [kclc_pkg::CHAR_W-1:0] ch;
	logic                        key_ok;
	logic                        master_hit;
	logic                        code_ok;
	logic [CNT_W-1:0]            count_inc;
	logic [kclc_pkg::FAIL_W-1:0] fail_inc;
	logic                        alarm;
	kclc_pkg::event_t            ev;

	assign ch        = kclc_pkg::key_to_ascii(key_code);
	assign key_ok    = (key_code >= 5'd1) && (key_code <= 5'd16);
	assign count_inc = count + CNT_W'(1);
	assign fail_inc  = (fail < kclc_pkg::FAIL_SAT) ? fail + 4'd1 : fail;

	always_comb begin
		for (int k = 0; k < ENTRY_LEN; k++) begin
			entry_buf_n[k] = (count == CNT_W'(k)) ? ch : entry_buf[k];
		end
	end

	generate
		if (ENTRY_LEN == 5) begin : g_master
			always_comb begin
				master_hit = 1'b1;
				for (int k = 0; k < 5; k++) begin
					if (entry_buf_n[k] != cfg.master_code[8*(4-k) +: 8]) begin
						master_hit = 1'b0;
					end
				end
			end
		end else begin : g_no_master
			assign master_hit = 1'b0;
		end
	endgenerate

	always_comb begin
		code_ok = (fail < cfg.max_failures) && (entry_buf_n[CODE_LENGTH] == kclc_pkg::CHAR_HASH);
		for (int k = 0; k < CODE_LENGTH; k++) begin
			if (entry_buf_n[k] != stored[k]) begin
				code_ok = 1'b0;
			end
		end
	end

	always_comb begin
		phase_n   = phase;
		count_n   = count;
		buf_we    = 1'b0;
		stored_we = 1'b0;
		fail_n    = fail;
		granted_n = granted;
		alarm     = 1'b0;
		ev        = kclc_pkg::EV_NONE;
		if (key_ok) begin
			unique case (phase)
				kclc_pkg::PH_IDLE: begin
					if (ch == kclc_pkg::CHAR_STAR) begin
						phase_n = kclc_pkg::PH_ENTRY;
						count_n = '0;
						ev      = kclc_pkg::EV_KEY;
					end
				end
				kclc_pkg::PH_MASTER: begin
					if (ch == kclc_pkg::CHAR_HASH) begin
						phase_n   = kclc_pkg::PH_NEWCODE;
						granted_n = 1'b0;
						count_n   = '0;
						ev        = kclc_pkg::EV_KEY;
					end else begin
						phase_n = kclc_pkg::PH_IDLE;
						count_n = '0;
						fail_n  = fail_inc;
						ev      = kclc_pkg::EV_DENIED;
						if (fail_inc >= cfg.max_failures) begin
							alarm     = 1'b1;
							ev        = kclc_pkg::EV_LOCKOUT;
							fail_n    = cfg.retained_failures;
							granted_n = 1'b0;
						end
					end
				end
				default: begin
					if (ch == kclc_pkg::CHAR_STAR) begin
						count_n = '0;
						ev      = kclc_pkg::EV_RESTART;
					end else begin
						buf_we  = (count < CNT_W'(ENTRY_LEN));
						count_n = count_inc;
						if (count_inc < CNT_W'(ENTRY_LEN)) begin
							ev = kclc_pkg::EV_KEY;
						end else if (phase == kclc_pkg::PH_ENTRY) begin
							if (master_hit) begin
								phase_n = kclc_pkg::PH_MASTER;
								ev      = kclc_pkg::EV_KEY;
							end else if (!code_ok) begin
								phase_n = kclc_pkg::PH_IDLE;
								count_n = '0;
								fail_n  = fail_inc;
								ev      = kclc_pkg::EV_DENIED;
								if (fail_inc >= cfg.max_failures) begin
									alarm     = 1'b1;
									ev        = kclc_pkg::EV_LOCKOUT;
									fail_n    = cfg.retained_failures;
									granted_n = 1'b0;
								end
							end else begin
								phase_n = kclc_pkg::PH_IDLE;
								count_n = '0;
								fail_n  = '0;
								if (granted || door_sensor) begin
									granted_n = 1'b0;
									ev        = kclc_pkg::EV_RELOCKED;
								end else begin
									granted_n = 1'b1;
									ev        = kclc_pkg::EV_GRANTED;
								end
							end
						end else begin
							phase_n = kclc_pkg::PH_IDLE;
							count_n = '0;
							if (entry_buf_n[CODE_LENGTH] == kclc_pkg::CHAR_HASH) begin
								stored_we = 1'b1;
								ev        = kclc_pkg::EV_CHANGED;
							end else begin
								ev = kclc_pkg::EV_CHG_ERR;
							end
						end
					end
				end
			endcase
		end
	end

	always_comb begin
		res.phase         = phase_n;
		res.key_char      = ch;
		res.position      = kclc_pkg::POS_W'(count_n);
		res.event_res     = ev;
		res.unlocked      = granted_n;
		res.lock_released = granted_n || (phase_n == kclc_pkg::PH_NEWCODE);
		res.alarm         = alarm;
		res.failures      = fail_n;
	end

endmodule

// ===== rtl/keypad_code_lock_controller.sv =====
// Top level of the keypad code lock controller: channels, state and config registers.
// Depends on kclc_pkg, kclc_if.sv and kclc_step.
//
// keys carries one keypad scan code and the door sensor level per transaction;
// results returns exactly one transaction per key: phase, key character, entry
// position, event code, unlock and lock-release levels, alarm pulse and failure count.
// A scan code outside 1..16 is ignored but still answered with event none.
// Registers on the APB port: master_code at 0x00 (40 bits), max_failures at 0x08,
// retained_failures at 0x10; write them only while no transaction is in flight.
// From acceptance to result valid: the input register loads at the accepting edge, and
// one pass of next-state logic then updates the lock state and loads the result register
// once the result register is free or being read. Throughput is one key per cycle while
// results does not stall; the single-pass state update is the only loop.
// When results stalls, the result register holds and the input register keeps
// the next key; keys.ready drops only once both are full.
// Reset returns to idle, clears the failure count and grant, restores the stored
// code "2580" and the register defaults; the entry buffer is undefined until written.
module keypad_code_lock_controller #(
	parameter int CODE_LENGTH = kclc_pkg::CODE_LENGTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	kclc_key_if.sink                      keys,
	kclc_res_if.source                    results,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [kclc_pkg::APB_AW-1:0]   paddr,
	input  logic [kclc_pkg::APB_DW-1:0]   pwdata,
	output logic [kclc_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);

	localparam int ENTRY_LEN = CODE_LENGTH + 1;
	localparam int CNT_W = $clog2(ENTRY_LEN + 1);

	kclc_pkg::cfg_t              cfg_q;
	logic                        wr_en;

	logic                        valid_s1;
	logic [kclc_pkg::KEY_W-1:0]  key_s1;
	logic                        sensor_s1;
	logic                        adv_s1;
	logic                        adv_s2;

	logic                        valid_s2;
	kclc_pkg::res_t              res_s2;

	kclc_pkg::phase_t            phase_q;
	logic [CNT_W-1:0]            count_q;
	logic [kclc_pkg::CHAR_W-1:0] entry_buf_q [ENTRY_LEN];
	logic [kclc_pkg::CHAR_W-1:0] stored_q [CODE_LENGTH];
	logic [kclc_pkg::FAIL_W-1:0] fail_q;
	logic                        granted_q;

	kclc_pkg::phase_t            phase_n;
	logic [CNT_W-1:0]            count_n;
	logic                        buf_we;
	logic [kclc_pkg::CHAR_W-1:0] entry_buf_n [ENTRY_LEN];
	logic                        stored_we;
	logic [kclc_pkg::FAIL_W-1:0] fail_n;
	logic                        granted_n;
	kclc_pkg::res_t              res_n;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.master_code       <= kclc_pkg::MASTER_RST;
			cfg_q.max_failures      <= kclc_pkg::MAX_FAIL_RST;
			cfg_q.retained_failures <= kclc_pkg::RETAIN_RST;
		end else if (wr_en) begin
			unique case (paddr[4:3])
				kclc_pkg::REG_MASTER:  cfg_q.master_code <= pwdata[kclc_pkg::MCODE_W-1:0];
				kclc_pkg::REG_MAXFAIL: cfg_q.max_failures <= pwdata[kclc_pkg::FAIL_W-1:0];
				kclc_pkg::REG_RETAIN:  cfg_q.retained_failures <= pwdata[kclc_pkg::FAIL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			kclc_pkg::REG_MASTER:  prdata = kclc_pkg::APB_DW'(cfg_q.master_code);
			kclc_pkg::REG_MAXFAIL: prdata = kclc_pkg::APB_DW'(cfg_q.max_failures);
			kclc_pkg::REG_RETAIN:  prdata = kclc_pkg::APB_DW'(cfg_q.retained_failures);
			default:               prdata = '0;
		endcase
	end

	assign adv_s2     = valid_s1 && (!valid_s2 || results.ready);
	assign adv_s1     = !valid_s1 || adv_s2;
	assign keys.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= keys.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && keys.valid) begin
			key_s1    <= keys.key_code;
			sensor_s1 <= keys.door_sensor;
		end
	end

	kclc_step #(
		.CODE_LENGTH(CODE_LENGTH)
	) u_step (
		.key_code    (key_s1),
		.door_sensor (sensor_s1),
		.cfg         (cfg_q),
		.phase       (phase_q),
		.count       (count_q),
		.entry_buf   (entry_buf_q),
		.stored      (stored_q),
		.fail        (fail_q),
		.granted     (granted_q),
		.phase_n     (phase_n),
		.count_n     (count_n),
		.buf_we      (buf_we),
		.entry_buf_n (entry_buf_n),
		.stored_we   (stored_we),
		.fail_n      (fail_n),
		.granted_n   (granted_n),
		.res         (res_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= kclc_pkg::PH_IDLE;
			count_q   <= '0;
			fail_q    <= '0;
			granted_q <= 1'b0;
			for (int k = 0; k < CODE_LENGTH; k++) begin
				stored_q[k] <= kclc_pkg::default_code_char(k);
			end
		end else if (adv_s2) begin
			phase_q   <= phase_n;
			count_q   <= count_n;
			fail_q    <= fail_n;
			granted_q <= granted_n;
			if (stored_we) begin
				for (int k = 0; k < CODE_LENGTH; k++) begin
					stored_q[k] <= entry_buf_n[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && buf_we) begin
			entry_buf_q <= entry_buf_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= 1'b1;
		end else if (results.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			res_s2 <= res_n;
		end
	end

	assign results.valid         = valid_s2;
	assign results.phase         = res_s2.phase;
	assign results.key_char      = res_s2.key_char;
	assign results.position      = res_s2.position;
	assign results.event_res     = res_s2.event_res;
	assign results.unlocked      = res_s2.unlocked;
	assign results.lock_released = res_s2.lock_released;
	assign results.alarm         = res_s2.alarm;
	assign results.failures      = res_s2.failures;

endmodule
